/* design/abshist_pkg.sv */
// abshist_pkg: shared types and constants of the age-bucketed sample history.
// Used by abshist_mem, abshist_ctrl and age_bucketed_sample_history_top.
`timescale 1ns / 1ps
`default_nettype none

package abshist_pkg;

  // Configuration register width and reset value
  localparam int SEC_W = 17;
  localparam logic [SEC_W-1:0] SLOT_SEC_RST = 17'd10800;

  // One input word: a new sample and the current time
  typedef struct packed {
    logic [31:0] take_time;
    logic [15:0] take_pressure;
    logic [31:0] now_time;
  } sample_t;

  // One output word: a reported slot
  typedef struct packed {
    logic [5:0]  slot_index;
    logic [31:0] slot_time;
    logic [15:0] slot_pressure;
    logic        last_slot;
  } slot_word_t;

  // One stored history entry
  typedef struct packed {
    logic [31:0] etime;
    logic [15:0] pressure;
  } entry_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_SCAN,
    ST_TAKE_RD,
    ST_TAKE,
    ST_EMIT_RD,
    ST_EMIT
  } state_t;

endpackage

`default_nettype wire

/* design/abshist_mem.sv */
// abshist_mem: history store, one entry per slot, one write and one read port.
// Registered read; per-entry valid bits make unwritten entries read as zero.
// Depends on abshist_pkg.
`timescale 1ns / 1ps
`default_nettype none

module abshist_mem #(
  parameter int SLOTS = 4,
  localparam int AW = $clog2(SLOTS)
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                rd_en,
  input  wire logic [AW-1:0]       rd_addr,
  output abshist_pkg::entry_t      rd_data,
  input  wire logic                wr_en,
  input  wire logic [AW-1:0]       wr_addr,
  input  wire abshist_pkg::entry_t wr_data
);

  abshist_pkg::entry_t mem [SLOTS];
  logic [SLOTS-1:0]    valid;
  abshist_pkg::entry_t rd_q;
  logic                rd_vld;

  // Entry array write
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Valid bits, cleared at reset
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr_en) begin
      valid[wr_addr] <= 1'b1;
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
    end else if (rd_en) begin
      rd_vld <= valid[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  // An entry never written since reset reads as zero
  assign rd_data = rd_vld ? rd_q : '0;

endmodule

`default_nettype wire

/* design/abshist_ctrl.sv */
// abshist_ctrl: sequencer that refreshes slots by scanning the store,
// conditionally replaces slot 0 and reads every slot out for reporting.
// Depends on abshist_pkg; drives abshist_mem.
`timescale 1ns / 1ps
`default_nettype none

module abshist_ctrl #(
  parameter int SLOTS = 4,
  localparam int AW = $clog2(SLOTS),
  localparam int LW = abshist_pkg::SEC_W + AW
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire abshist_pkg::sample_t           in_word,
  input  wire logic [abshist_pkg::SEC_W-1:0]  slot_seconds,
  output logic                                rd_en,
  output logic [AW-1:0]                       rd_addr,
  input  wire abshist_pkg::entry_t            rd_data,
  output logic                                wr_en,
  output logic [AW-1:0]                       wr_addr,
  output abshist_pkg::entry_t                 wr_data,
  input  wire logic                           out_free,
  output logic                                out_load,
  output abshist_pkg::slot_word_t             out_word
);

  localparam logic [AW-1:0] LAST = AW'(SLOTS - 1);

  abshist_pkg::state_t state, state_next;
  logic [AW-1:0]        i, i_next;
  logic [AW-1:0]        k, k_next;
  logic [AW-1:0]        j, j_next;
  logic [LW-1:0]        lo, lo_next;
  abshist_pkg::sample_t smp, smp_next;

  logic [LW:0]  w_ext;
  logic [LW:0]  hi;
  logic [32:0]  age;
  logic [32:0]  tdiff;
  logic         match;
  logic         take_ok;

  // Bucket bounds and age compare for the slot being refreshed
  assign w_ext = (LW+1)'(slot_seconds);
  assign hi    = (LW+1)'(lo) + w_ext + ((i == LAST) ? w_ext : '0);
  assign age   = {1'b0, smp.now_time} - {1'b0, rd_data.etime};
  assign match = !age[32] && (age[31:0] >= 32'(lo)) && (age[31:0] < 32'(hi));

  // Slot 0 replacement test: at least one period since slot 0's time
  assign tdiff   = {1'b0, smp.take_time} - {1'b0, rd_data.etime};
  assign take_ok = !tdiff[32] && (tdiff[31:0] >= 32'(slot_seconds));

  // State and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= abshist_pkg::ST_IDLE;
      i     <= '0;
      k     <= '0;
      j     <= '0;
    end else begin
      state <= state_next;
      i     <= i_next;
      k     <= k_next;
      j     <= j_next;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    lo  <= lo_next;
    smp <= smp_next;
  end

  // Next state and outputs
  always_comb begin
    state_next = state;
    i_next     = i;
    k_next     = k;
    j_next     = j;
    lo_next    = lo;
    smp_next   = smp;
    in_stall   = 1'b1;
    rd_en      = 1'b0;
    rd_addr    = k;
    wr_en      = 1'b0;
    wr_addr    = i;
    wr_data    = rd_data;
    out_load   = 1'b0;
    out_word.slot_index    = 6'(j);
    out_word.slot_time     = rd_data.etime;
    out_word.slot_pressure = rd_data.pressure;
    out_word.last_slot     = (j == LAST);
    case (state)
      abshist_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          smp_next   = in_word;
          i_next     = LAST;
          state_next = abshist_pkg::ST_SETUP;
        end
      end
      // Lower bound of slot i, first read of the scan
      abshist_pkg::ST_SETUP: begin
        lo_next    = LW'(slot_seconds) * LW'(i);
        k_next     = i;
        rd_en      = 1'b1;
        rd_addr    = i;
        state_next = abshist_pkg::ST_SCAN;
      end
      // One stored entry checked per cycle, next one read ahead
      abshist_pkg::ST_SCAN: begin
        if (match || (k == '0)) begin
          wr_en   = 1'b1;
          wr_addr = i;
          wr_data = match ? rd_data : '0;
          if (i == AW'(1)) begin
            state_next = abshist_pkg::ST_TAKE_RD;
          end else begin
            i_next     = i - AW'(1);
            state_next = abshist_pkg::ST_SETUP;
          end
        end else begin
          rd_en   = 1'b1;
          rd_addr = k - AW'(1);
          k_next  = k - AW'(1);
        end
      end
      abshist_pkg::ST_TAKE_RD: begin
        rd_en      = 1'b1;
        rd_addr    = '0;
        state_next = abshist_pkg::ST_TAKE;
      end
      abshist_pkg::ST_TAKE: begin
        if (take_ok) begin
          wr_en            = 1'b1;
          wr_addr          = '0;
          wr_data.etime    = smp.take_time;
          wr_data.pressure = smp.take_pressure;
        end
        j_next     = '0;
        state_next = abshist_pkg::ST_EMIT_RD;
      end
      // Read slot j once the output register will be free
      abshist_pkg::ST_EMIT_RD: begin
        if (out_free) begin
          rd_en      = 1'b1;
          rd_addr    = j;
          state_next = abshist_pkg::ST_EMIT;
        end
      end
      abshist_pkg::ST_EMIT: begin
        out_load = 1'b1;
        if (j == LAST) begin
          state_next = abshist_pkg::ST_IDLE;
        end else begin
          j_next     = j + AW'(1);
          state_next = abshist_pkg::ST_EMIT_RD;
        end
      end
      default: begin
        state_next = abshist_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* design/age_bucketed_sample_history_top.sv */
// age_bucketed_sample_history_top: top level with the slot_seconds register,
// the output word register, the sequencer and the history store.
// Depends on abshist_pkg, abshist_mem, abshist_ctrl.
//
// Usage:
//   in channel (in_valid / in_stall / in_word): one sample word with its own
//   time, pressure and the current time. A word is taken when in_valid is
//   high and in_stall low; in_stall stays high until the report is done.
//   out channel (out_valid / out_stall / out_word): SLOTS words per sample,
//   slot 0 first, last_slot set on slot SLOTS-1.
//   cfg channel (cfg_valid / cfg_ready / cfg_data): writes slot_seconds,
//   always ready; write only while the block is idle.
// Steps per sample: accept, then for each slot i from SLOTS-1 down to 1 a
// setup step and a scan of stored entries from slot i downwards (1 to i+1
// entries checked, one memory read each), then a read and check of slot 0
// and a read and load for each reported slot. The single read port of the
// store makes these steps run one after another.
// Reset: all slots read as zero and slot_seconds returns to 10800.
// A stalled receiver holds the output word; the read-out waits meanwhile.
`timescale 1ns / 1ps
`default_nettype none

module age_bucketed_sample_history_top #(
  parameter int SLOTS = 4
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire abshist_pkg::sample_t           in_word,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output abshist_pkg::slot_word_t             out_word,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [abshist_pkg::SEC_W-1:0]  cfg_data
);

  localparam int AW = $clog2(SLOTS);

  logic [abshist_pkg::SEC_W-1:0] slot_seconds;
  logic                          rd_en;
  logic [AW-1:0]                 rd_addr;
  abshist_pkg::entry_t           rd_data;
  logic                          wr_en;
  logic [AW-1:0]                 wr_addr;
  abshist_pkg::entry_t           wr_data;
  logic                          out_free;
  logic                          out_load;
  abshist_pkg::slot_word_t       load_word;

  // Configuration register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_seconds <= abshist_pkg::SLOT_SEC_RST;
    end else if (cfg_valid && cfg_ready) begin
      slot_seconds <= cfg_data;
    end
  end

  // Output word register
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_word <= load_word;
    end
  end

  abshist_ctrl #(
    .SLOTS (SLOTS)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_word      (in_word),
    .slot_seconds (slot_seconds),
    .rd_en        (rd_en),
    .rd_addr      (rd_addr),
    .rd_data      (rd_data),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data),
    .out_free     (out_free),
    .out_load     (out_load),
    .out_word     (load_word)
  );

  abshist_mem #(
    .SLOTS (SLOTS)
  ) u_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

`ifndef SYNTHESIS
  // A loaded word never overwrites one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_load |-> (!out_valid || !out_stall))
    else $error("output word overwritten");

  // The store is never read and written at one entry in the same cycle
  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    (rd_en && wr_en) |-> (rd_addr != wr_addr))
    else $error("read and write of one entry in one cycle");

  // An accepted sample holds off the next one
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken while busy");

  // The last reported slot frees the input side
  a_idle_after_last: assert property (@(posedge clk) disable iff (rst)
    (out_load && load_word.last_slot) |=> !in_stall)
    else $error("not idle after last slot");
`endif

endmodule

`default_nettype wire

/* sim/abshist_history_checker.sv */
// abshist_history_checker: watches the sample, slot and config channels of the
// age-bucketed sample history, predicts every slot word and compares them.
// Depends on abshist_pkg.
`timescale 1ns / 1ps

module abshist_history_checker #(
  parameter int SLOTS = 4
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  input  logic                               in_stall,
  input  abshist_pkg::sample_t               in_word,
  input  logic                               out_valid,
  input  logic                               out_stall,
  input  abshist_pkg::slot_word_t            out_word,
  input  logic                               cfg_valid,
  input  logic                               cfg_ready,
  input  logic [abshist_pkg::SEC_W-1:0]      cfg_data,
  output int                                 fail_count,
  output int                                 pending_slots
);
  import abshist_pkg::*;

  // Predicted history and bucket width
  logic [31:0]      hist_time [SLOTS];
  logic [15:0]      hist_pres [SLOTS];
  logic [SEC_W-1:0] bucket_sec;
  slot_word_t       expected_slots [$];
  int               errs = 0;

  // True when an age falls in the bucket of slot pos; the last bucket is doubled
  function automatic bit age_fits(input int unsigned pos, input longint age);
    longint w;
    longint lo;
    longint hi;
    w  = longint'({47'd0, bucket_sec});
    lo = w * longint'({32'd0, pos});
    hi = lo + w;
    if (pos == SLOTS - 1) hi = hi + w;
    return (age >= lo) && (age < hi);
  endfunction

  // Age the history by one sample, maybe take it into slot 0, queue the report
  task automatic age_and_take(input sample_t s);
    longint     age;
    bit         hit;
    slot_word_t w;
    for (int i = SLOTS - 1; i > 0; i--) begin
      hit = 1'b0;
      for (int k = i; k >= 0 && !hit; k--) begin
        age = longint'({32'd0, s.now_time}) - longint'({32'd0, hist_time[k]});
        if (age_fits(i, age)) begin
          hist_time[i] = hist_time[k];
          hist_pres[i] = hist_pres[k];
          hit = 1'b1;
        end
      end
      if (!hit) begin
        hist_time[i] = '0;
        hist_pres[i] = '0;
      end
    end
    // a new sample only lands once a full bucket has passed since slot 0
    if (longint'({32'd0, s.take_time}) - longint'({32'd0, hist_time[0]}) >=
        longint'({47'd0, bucket_sec})) begin
      hist_time[0] = s.take_time;
      hist_pres[0] = s.take_pressure;
    end
    for (int i = 0; i < SLOTS; i++) begin
      w.slot_index    = 6'(i);
      w.slot_time     = hist_time[i];
      w.slot_pressure = hist_pres[i];
      w.last_slot     = (i == SLOTS - 1);
      expected_slots.push_back(w);
    end
  endtask

  // Compare one slot word with the oldest prediction
  task automatic check_slot_word(input slot_word_t got);
    slot_word_t want;
    if (expected_slots.size() == 0) begin
      errs = errs + 1;
      if (errs <= 10)
        $display("unexpected slot word: idx %0d time %0d pres %0d last %0b",
                 got.slot_index, got.slot_time, got.slot_pressure, got.last_slot);
    end else begin
      want = expected_slots.pop_front();
      if (got.slot_index !== want.slot_index || got.slot_time !== want.slot_time ||
          got.slot_pressure !== want.slot_pressure ||
          got.last_slot !== want.last_slot) begin
        errs = errs + 1;
        if (errs <= 10)
          $display("slot word mismatch: want idx %0d time %0d pres %0d last %0b, got idx %0d time %0d pres %0d last %0b",
                   want.slot_index, want.slot_time, want.slot_pressure, want.last_slot,
                   got.slot_index, got.slot_time, got.slot_pressure, got.last_slot);
      end
    end
  endtask

  // Channel monitor; config before samples before slot words
  always @(posedge clk) begin
    if (rst) begin
      bucket_sec = SLOT_SEC_RST;
      for (int i = 0; i < SLOTS; i++) begin
        hist_time[i] = '0;
        hist_pres[i] = '0;
      end
      expected_slots.delete();
    end else begin
      if (cfg_valid && cfg_ready) bucket_sec = cfg_data;
      if (in_valid && !in_stall) age_and_take(in_word);
      if (out_valid && !out_stall) check_slot_word(out_word);
    end
    pending_slots <= expected_slots.size();
    fail_count <= errs;
  end

endmodule

/* sim/age_bucketed_sample_history_top_tb.sv */
// age_bucketed_sample_history_top_tb: drives samples and slot_seconds writes into
// the sample history with random idling and gives the verdict.
// Depends on abshist_pkg, age_bucketed_sample_history_top, abshist_history_checker.
`timescale 1ns / 1ps

module age_bucketed_sample_history_top_tb;
  import abshist_pkg::*;

  localparam int          N_SLOTS     = 4;
  localparam int unsigned DFLT_SEC    = 10800;
  localparam int          GROUP_ITEMS = 23;
  localparam int          HOLD_CYCLES = 400;
  localparam int          STUCK_LIMIT = 5000;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_stall;
  sample_t          in_word = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  slot_word_t       out_word;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [SEC_W-1:0] cfg_data = '0;

  int               fail_count;
  int               pending_slots;
  int               tx_idle_pct = 0;
  int               rx_idle_pct = 0;
  int               hold_requests = 0;
  int               stuck_cycles = 0;
  int unsigned      cur_sec = DFLT_SEC;
  int unsigned      wall_clock = 0;
  logic             moved;

  always #4 clk = ~clk;

  age_bucketed_sample_history_top #(.SLOTS(N_SLOTS)) dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  abshist_history_checker #(.SLOTS(N_SLOTS)) chk (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_word       (in_word),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_word      (out_word),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .pending_slots (pending_slots)
  );

  // Receiver: random stalls, plus a long hold-off on request
  initial begin : receiver
    int hold_left;
    int served;
    hold_left = 0;
    served = 0;
    forever begin
      @(posedge clk);
      if (served != hold_requests) begin
        served = hold_requests;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
      end
    end
  end

  // Watchdog on cycles with no word moving on any channel
  assign moved = (in_valid && !in_stall) || (out_valid && !out_stall) ||
                 (cfg_valid && cfg_ready);

  always @(posedge clk) begin
    if (!rst) begin
      stuck_cycles <= moved ? 0 : stuck_cycles + 1;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // Offer one sample word, with a random gap first
  task automatic send_sample(input sample_t s);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= s;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic reading(input logic [31:0] t, input logic [15:0] p, input logic [31:0] n);
    sample_t s;
    s.take_time     = t;
    s.take_pressure = p;
    s.now_time      = n;
    send_sample(s);
  endtask

  // Stop offering and wait for every predicted slot word
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_slots != 0);
  endtask

  task automatic write_slot_seconds(input int unsigned v);
    cfg_valid <= 1'b1;
    cfg_data  <= SEC_W'(v);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cur_sec = v;
  endtask

  // Mostly a clock running forward, some out-of-order stamps, some raw noise
  task automatic make_reading(output sample_t s);
    int unsigned roll;
    int unsigned span;
    roll = $urandom_range(0, 99);
    span = (cur_sec == 0) ? 4 : cur_sec;
    s.take_pressure = 16'($urandom_range(0, 16'hFFFF));
    if (roll < 70) begin
      wall_clock  = wall_clock + $urandom_range(0, span + span / 2);
      s.now_time  = wall_clock;
      s.take_time = wall_clock - $urandom_range(0, span / 8);
    end else if (roll < 85) begin
      // sample stamped ahead of now, or now stepped back
      s.now_time  = wall_clock - $urandom_range(0, 2 * span);
      s.take_time = wall_clock + $urandom_range(0, span);
    end else begin
      s.take_time = $urandom();
      s.now_time  = $urandom();
    end
  endtask

  // Stimulus
  initial begin : stimulus
    localparam logic [31:0] BASE = 32'h1000_0000;
    int unsigned phase_sec [6];
    sample_t     s;
    phase_sec = '{1, 131071, 0, 86400, 0, DFLT_SEC};
    phase_sec[4] = $urandom_range(2, 5000);

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    tx_idle_pct <= 21;
    rx_idle_pct <= 65;

    // directed: bucket fill at reset width, edges, negative ages, extremes
    reading(0, 16'h0000, 0);
    reading(0, 16'hFFFF, DFLT_SEC);
    reading(DFLT_SEC, 16'h1234, DFLT_SEC);
    reading(2 * DFLT_SEC, 16'hBEEF, 2 * DFLT_SEC);
    reading(3 * DFLT_SEC, 16'h5A5A, 3 * DFLT_SEC);
    reading(4 * DFLT_SEC, 16'hA5A5, 4 * DFLT_SEC);
    reading(5 * DFLT_SEC, 16'h0001, 5 * DFLT_SEC + DFLT_SEC / 2);
    reading(6 * DFLT_SEC + 1, 16'h8000, 0);
    reading(0, 16'h7FFF, 7 * DFLT_SEC);
    reading(32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
    reading(32'hFFFF_FFFF, 16'h0000, 0);
    reading(0, 16'hFFFF, 32'hFFFF_FFFF);
    reading(BASE, 16'h0F0F, BASE);
    reading(BASE + DFLT_SEC - 1, 16'hF0F0, BASE + DFLT_SEC - 1);
    reading(BASE + DFLT_SEC, 16'h3C3C, BASE + DFLT_SEC);
    reading(BASE + DFLT_SEC, 16'hC3C3, BASE + 2 * DFLT_SEC - 1);
    reading(BASE + 2 * DFLT_SEC, 16'h1111, BASE + 3 * DFLT_SEC);
    reading(BASE + 5 * DFLT_SEC - 1, 16'h2222, BASE + 5 * DFLT_SEC - 1);
    reading(BASE + 5 * DFLT_SEC, 16'h4444, BASE + 5 * DFLT_SEC);
    reading(BASE + 6 * DFLT_SEC, 16'h8888, BASE + 7 * DFLT_SEC);

    // random groups, one bucket width each
    for (int g = 0; g < 6; g++) begin
      if (g == 2) begin
        tx_idle_pct <= 65;
        rx_idle_pct <= 21;
      end else if (g == 4) begin
        tx_idle_pct <= 0;
        rx_idle_pct <= 0;
      end
      wait_drained();
      write_slot_seconds(phase_sec[g]);
      wall_clock = $urandom_range(0, 32'hF000_0000);
      // long receiver hold-off while samples keep coming
      if (g == 2) hold_requests <= hold_requests + 1;
      for (int n = 0; n < GROUP_ITEMS; n++) begin
        if (g == 4 && n == GROUP_ITEMS / 2) wait_drained();
        make_reading(s);
        send_sample(s);
      end
    end

    wait_drained();
    repeat (40) @(posedge clk);
    if (fail_count == 0 && pending_slots == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
design/abshist_pkg.sv
design/abshist_mem.sv
design/abshist_ctrl.sv
design/age_bucketed_sample_history_top.sv
sim/abshist_history_checker.sv
sim/age_bucketed_sample_history_top_tb.sv
